[rtl/vector_refraction_macros.svh]
// Assertion helpers used by vector_refraction.
`ifndef VECTOR_REFRACTION_MACROS_SVH
`define VECTOR_REFRACTION_MACROS_SVH

// Assert a property on the rising clock edge, off while reset is active.
`define VR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Assert that an antecedent implies a consequent in the next cycle.
`define VR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/vref_pkg.sv]
// ----------------------------------------------------------------------------
// vref_pkg
// Shared constants for the vector refraction pipeline.
// ----------------------------------------------------------------------------
package vref_pkg;
  localparam int unsigned RATIO_WIDTH = 16;
  localparam int unsigned RATIO_FB    = 12;
endpackage

[rtl/vector_refraction.sv]
// ----------------------------------------------------------------------------
// vector_refraction
// Snell refraction of a unit direction about a unit normal, fixed point.
// ----------------------------------------------------------------------------
// Accepts one ray per cycle while the output is not stalled and returns one
// refracted direction per ray, in order, through eight front stages, the
// square root unit, which retires two root bits per stage, the root * n stage
// and the output register. The whole pipeline advances together: a stall on
// the output freezes every stage, and an empty output register lets the
// pipeline keep moving. Components are signed Q2.(W-2), the index ratio
// unsigned Q4.12; results saturate and there is no total internal reflection
// flag (the magnitude under the root is used).
module vector_refraction
  import vref_pkg::*;
#(
  parameter int unsigned COMPONENT_WIDTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [COMPONENT_WIDTH-1:0] incident_x_i,
  input  logic signed [COMPONENT_WIDTH-1:0] incident_y_i,
  input  logic signed [COMPONENT_WIDTH-1:0] incident_z_i,
  input  logic signed [COMPONENT_WIDTH-1:0] normal_x_i,
  input  logic signed [COMPONENT_WIDTH-1:0] normal_y_i,
  input  logic signed [COMPONENT_WIDTH-1:0] normal_z_i,
  input  logic        [RATIO_WIDTH-1:0]     index_ratio_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [COMPONENT_WIDTH-1:0] refracted_x_o,
  output logic signed [COMPONENT_WIDTH-1:0] refracted_y_o,
  output logic signed [COMPONENT_WIDTH-1:0] refracted_z_o
);
  `include "vector_refraction_macros.svh"

  localparam int unsigned W   = COMPONENT_WIDTH;
  localparam int unsigned F   = W - 2;
  localparam int unsigned PW  = 2 * W;          // product width
  localparam int unsigned AW  = W + 2;          // u + cos*n
  localparam int unsigned EW  = AW + RATIO_WIDTH + 1;
  localparam int unsigned SW  = 2 * W + 2;      // sum of squares
  localparam int unsigned RW  = (SW + 1) / 2;   // root width
  localparam int unsigned NST = (RW + 1) / 2;

  typedef logic signed [W-1:0] comp_t;
  typedef comp_t vec_t [3];

  // rounding shift right, half up (floor of v + half)
  function automatic logic signed [PW+RATIO_WIDTH:0] rnd_sh(
    input logic signed [PW+RATIO_WIDTH:0] v, input int unsigned s);
    logic signed [PW+RATIO_WIDTH:0] t;
    t = v + (($signed({{(PW+RATIO_WIDTH){1'b0}}, 1'b1})) <<< (s - 1));
    return t >>> s;
  endfunction

  function automatic comp_t sat_w(input logic signed [PW+RATIO_WIDTH:0] v);
    logic signed [PW+RATIO_WIDTH:0] mx, mn;
    mx = $signed({{(PW+RATIO_WIDTH-W+2){1'b0}}, {(W-1){1'b1}}});
    mn = -mx - 1;
    if (v > mx) return comp_t'(mx);
    if (v < mn) return comp_t'(mn);
    return comp_t'(v);
  endfunction

  // global advance: all stages move when the output register can take data
  logic adv;
  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;

  // stage 1: register inputs
  vec_t u1_q, n1_q;
  logic [RATIO_WIDTH-1:0] eta1_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      u1_q   <= '{incident_x_i, incident_y_i, incident_z_i};
      n1_q   <= '{normal_x_i, normal_y_i, normal_z_i};
      eta1_q <= index_ratio_i;
    end
  end

  // stage 2: dot products
  logic signed [PW-1:0] dp2_q [3];
  vec_t u2_q, n2_q;
  logic [RATIO_WIDTH-1:0] eta2_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) dp2_q[i] <= u1_q[i] * n1_q[i];
      u2_q <= u1_q; n2_q <= n1_q; eta2_q <= eta1_q;
    end
  end

  // stage 3: cosine, rounded sum, negated and clamped
  comp_t cos3_q;
  vec_t u3_q, n3_q;
  logic [RATIO_WIDTH-1:0] eta3_q;
  logic signed [PW+RATIO_WIDTH:0] cos_sum;
  logic signed [PW+RATIO_WIDTH:0] cos_one, cos_min;
  always_comb begin
    cos_sum = '0;
    for (int i = 0; i < 3; i++)
      cos_sum = cos_sum + rnd_sh((PW+RATIO_WIDTH+1)'(dp2_q[i]), F);
    cos_sum = -cos_sum;
    cos_one = (PW+RATIO_WIDTH+1)'(1) <<< F;
    cos_min = -((PW+RATIO_WIDTH+1)'(1) <<< (W - 1));
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (cos_sum > cos_one)      cos3_q <= comp_t'(cos_one);
      else if (cos_sum < cos_min) cos3_q <= comp_t'(cos_min);
      else                        cos3_q <= comp_t'(cos_sum);
      u3_q <= u2_q; n3_q <= n2_q; eta3_q <= eta2_q;
    end
  end

  // stage 4: cos * n
  logic signed [PW-1:0] cn4_q [3];
  vec_t u4_q, n4_q;
  logic [RATIO_WIDTH-1:0] eta4_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) cn4_q[i] <= cos3_q * n3_q[i];
      u4_q <= u3_q; n4_q <= n3_q; eta4_q <= eta3_q;
    end
  end

  // stage 5: a = u + rnd(cos*n)
  logic signed [AW-1:0] a5_q [3];
  vec_t n5_q;
  logic [RATIO_WIDTH-1:0] eta5_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++)
        a5_q[i] <= AW'((PW+RATIO_WIDTH+1)'(u4_q[i])
                       + rnd_sh((PW+RATIO_WIDTH+1)'(cn4_q[i]), F));
      n5_q <= n4_q; eta5_q <= eta4_q;
    end
  end

  // stage 6: eta * a
  logic signed [EW-1:0] ea6_q [3];
  vec_t n6_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++)
        ea6_q[i] <= $signed({1'b0, eta5_q}) * a5_q[i];
      n6_q <= n5_q;
    end
  end

  // stage 7: perp = sat(rnd(eta*a, 12))
  vec_t p7_q, n7_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++)
        p7_q[i] <= sat_w(rnd_sh((PW+RATIO_WIDTH+1)'(ea6_q[i]), RATIO_FB));
      n7_q <= n6_q;
    end
  end

  // stage 8: squares, operands widened first so the product is full width
  logic [PW-1:0] sq8_q [3];
  vec_t p8_q, n8_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) sq8_q[i] <= PW'(p7_q[i]) * PW'(p7_q[i]);
      p8_q <= p7_q; n8_q <= n7_q;
    end
  end

  // radicand |1 - |perp|^2|, then the root pipeline carries perp and n along
  logic [SW-1:0] sq_tot, one_sq, rad;
  always_comb begin
    sq_tot = SW'(sq8_q[0]) + SW'(sq8_q[1]) + SW'(sq8_q[2]);
    one_sq = SW'(1) << (2 * F);
    rad    = (sq_tot >= one_sq) ? (sq_tot - one_sq) : (one_sq - sq_tot);
  end

  localparam int unsigned TW = 6 * W;
  logic [TW-1:0] tag_in, tag_out;
  logic [RW-1:0] root;
  assign tag_in = {p8_q[0], p8_q[1], p8_q[2], n8_q[0], n8_q[1], n8_q[2]};

  // SW is even, so the radicand fills the root unit input exactly
  vref_sqrt #(.RW(RW), .TW(TW)) u_sqrt (
    .clk_i (clk_i), .rst_ni(rst_ni), .adv_i(adv),
    .rad_i (rad), .tag_i(tag_in),
    .root_o(root), .tag_o(tag_out)
  );

  // root * n stage
  logic signed [RW+W:0] rn_q [3];
  vec_t pr_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        rn_q[i] <= $signed({1'b0, root}) * $signed(tag_out[(2-i)*W +: W]);
        pr_q[i] <= tag_out[(5-i)*W +: W];
      end
    end
  end

  // output register
  comp_t out_q [3];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++)
        out_q[i] <= sat_w((PW+RATIO_WIDTH+1)'(pr_q[i])
                          - rnd_sh((PW+RATIO_WIDTH+1)'(rn_q[i]), F));
    end
  end

  // valid pipeline: 8 front stages, NST root stages, root*n, output
  localparam int unsigned VD = 8 + NST + 2;
  logic [VD-1:0] v_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[VD-2:0], in_valid_i};
    end
  end

  assign out_valid_o   = v_q[VD-1];
  assign refracted_x_o = out_q[0];
  assign refracted_y_o = out_q[1];
  assign refracted_z_o = out_q[2];

  `VR_ASSERT_NEXT(a_hold, out_valid_o && out_stall_i, out_valid_o && $stable(refracted_x_o),
                  "result changed while stalled")
  `VR_ASSERT(a_stall, in_stall_o == (out_valid_o && out_stall_i),
             "input stall not tied to output back pressure")
  `VR_ASSERT_NEXT(a_flow, !in_stall_o && !in_valid_i, !v_q[0],
                  "bubble not inserted")
endmodule

[rtl/vref_sqrt.sv]
// ----------------------------------------------------------------------------
// vref_sqrt
// Pipelined restoring integer square root, two result bits per stage.
// ----------------------------------------------------------------------------
module vref_sqrt
  import vref_pkg::*;
#(
  parameter int unsigned RW = 16,
  parameter int unsigned TW = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  logic [2*RW-1:0] rad_i,
  input  logic [TW-1:0]   tag_i,
  output logic [RW-1:0]   root_o,
  output logic [TW-1:0]   tag_o
);
  localparam int unsigned NST = (RW + 1) / 2;
  localparam int unsigned BPS = 2;

  logic [2*RW-1:0] rem_q  [NST+1];
  logic [RW-1:0]   res_q  [NST+1];
  logic [2*RW-1:0] rad_q  [NST+1];
  logic [TW-1:0]   tag_q  [NST+1];

  always_comb begin
    rem_q[0] = '0;
    res_q[0] = '0;
    rad_q[0] = rad_i;
    tag_q[0] = tag_i;
  end

  for (genvar s = 0; s < NST; s++) begin : g_st
    logic [2*RW-1:0] rem_d, rad_d;
    logic [RW-1:0]   res_d;
    logic [2*RW-1:0] rem_r, rad_r;
    logic [RW-1:0]   res_r;
    logic [TW-1:0]   tag_r;
    always_comb begin
      logic [2*RW+1:0] r;
      logic [2*RW+1:0] t;
      rem_d = rem_q[s];
      res_d = res_q[s];
      rad_d = rad_q[s];
      for (int b = 0; b < BPS; b++) begin
        if ((s * BPS + b) < RW) begin
          r = {rem_d, rad_d[2*RW-1 -: 2]};
          t = {res_d, 2'b01};
          rad_d = {rad_d[2*RW-3:0], 2'b00};
          if (r >= t) begin
            rem_d = r[2*RW-1:0] - t[2*RW-1:0];
            res_d = {res_d[RW-2:0], 1'b1};
          end else begin
            rem_d = r[2*RW-1:0];
            res_d = {res_d[RW-2:0], 1'b0};
          end
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_r <= rem_d;
        res_r <= res_d;
        rad_r <= rad_d;
        tag_r <= tag_q[s];
      end
    end
    always_comb begin
      rem_q[s+1] = rem_r;
      res_q[s+1] = res_r;
      rad_q[s+1] = rad_r;
      tag_q[s+1] = tag_r;
    end
  end

  assign root_o = res_q[NST];
  assign tag_o  = tag_q[NST];

  logic unused_rst;
  assign unused_rst = rst_ni;
endmodule
